// ----- rtl/core/coe_pkg.sv -----
// shared types and constants for the clock offset estimator
// no dependencies
package coe_pkg;

  // input word: one timestamp exchange
  typedef struct packed {
    logic [63:0] send_time;
    logic [63:0] master_time;
    logic [63:0] receive_time;
    logic [2:0]  cpu_index;
    logic        last_sample;
  } coe_in_t;

  // result word
  typedef struct packed {
    logic        [63:0] round_trip;
    logic signed [63:0] master_lead;
    logic signed [63:0] offset_estimate;
  } coe_out_t;

  // kept sample of a round, with its span
  typedef struct packed {
    logic [63:0] snd;
    logic [63:0] rcv;
    logic [63:0] mst;
    logic [63:0] span;
  } coe_smp_t;

  // end-of-round values before filtering
  typedef struct packed {
    logic [63:0] round_trip;
    logic [63:0] master_lead;
    logic [63:0] raw_offset;
  } coe_res_t;

  localparam logic [63:0] SPAN_INIT = {64{1'b1}};
  localparam logic [63:0] RCV_INIT  = {64{1'b1}};

  // divide by five: n = a*2^17 + b = 5*(26214*a) + (2a + b)
  localparam int          DIV_LO_W   = 17;
  localparam logic [14:0] DIV_HI_MUL = 15'd26214;
  localparam logic [19:0] RECIP5     = 20'd838861;   // ceil(2^22 / 5)
  localparam int          RECIP_SH   = 22;
  localparam int          DIV_LAT    = 4;

endpackage

// ----- rtl/core/coe_best.sv -----
// input register and per-round minimum round-trip tracking
// depends on coe_pkg
module coe_best #(
  parameter int TAG_W = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              acc,
  input  coe_pkg::coe_in_t  in_word,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              kept_vld,
  output coe_pkg::coe_smp_t kept,
  output logic [TAG_W-1:0]  kept_tag,
  output logic              pend_last
);
  import coe_pkg::*;

  logic             v1_r;
  logic             last1_r;
  logic [TAG_W-1:0] tag1_r;
  coe_smp_t         smp1_r;
  coe_smp_t         best_r;
  coe_smp_t         sel;
  logic             better;
  logic             v2_r;
  coe_smp_t         k2_r;
  logic [TAG_W-1:0] tag2_r;

  // strict compare so ties keep the earlier sample
  assign better = smp1_r.span < best_r.span;
  assign sel    = better ? smp1_r : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      best_r.snd  <= '0;
      best_r.rcv  <= RCV_INIT;
      best_r.mst  <= '0;
      best_r.span <= SPAN_INIT;
    end else if (en) begin
      v1_r <= acc;
      v2_r <= v1_r && last1_r;
      if (v1_r) begin
        if (last1_r) begin
          best_r.snd  <= '0;
          best_r.rcv  <= RCV_INIT;
          best_r.mst  <= '0;
          best_r.span <= SPAN_INIT;
        end else if (better) begin
          best_r <= smp1_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (acc) begin
        smp1_r.snd  <= in_word.send_time;
        smp1_r.rcv  <= in_word.receive_time;
        smp1_r.mst  <= in_word.master_time;
        smp1_r.span <= in_word.receive_time - in_word.send_time;
        last1_r     <= in_word.last_sample;
        tag1_r      <= in_tag;
      end
      k2_r   <= sel;
      tag2_r <= tag1_r;
    end
  end

  assign kept_vld  = v2_r;
  assign kept      = k2_r;
  assign kept_tag  = tag2_r;
  assign pend_last = (v1_r && last1_r) || v2_r;

endmodule

// ----- rtl/core/coe_raw.sv -----
// master lead and overflow-free midpoint offset, two stages
// depends on coe_pkg
module coe_raw #(
  parameter int TAG_W = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              kept_vld,
  input  coe_pkg::coe_smp_t kept,
  input  logic [TAG_W-1:0]  kept_tag,
  output logic              res_vld,
  output coe_pkg::coe_res_t res,
  output logic [TAG_W-1:0]  res_tag,
  output logic              pend_last
);
  import coe_pkg::*;

  logic             v3_r;
  logic [63:0]      lead3_r;
  logic [63:0]      mid3_r;
  logic [63:0]      mst3_r;
  logic [63:0]      span3_r;
  logic [TAG_W-1:0] tag3_r;
  logic             v4_r;
  coe_res_t         res4_r;
  logic [TAG_W-1:0] tag4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v3_r <= kept_vld;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lead3_r <= kept.mst - kept.snd;
      // halves summed, plus one when both are odd
      mid3_r  <= (kept.snd >> 1) + (kept.rcv >> 1) + 64'(kept.snd[0] & kept.rcv[0]);
      mst3_r  <= kept.mst;
      span3_r <= kept.span;
      tag3_r  <= kept_tag;
      res4_r.round_trip  <= span3_r;
      res4_r.master_lead <= lead3_r;
      res4_r.raw_offset  <= mid3_r - mst3_r;
      tag4_r  <= tag3_r;
    end
  end

  assign res_vld   = v4_r;
  assign res       = res4_r;
  assign res_tag   = tag4_r;
  assign pend_last = v3_r || v4_r;

endmodule

// ----- rtl/core/coe_div5.sv -----
// signed divide by five, truncating toward zero, four register stages
// depends on coe_pkg
module coe_div5 (
  input  logic        clk,
  input  logic        en,
  input  logic [34:0] x,
  output logic [31:0] q
);
  import coe_pkg::*;

  logic        neg1_r, neg2_r, neg3_r, neg4_r;
  logic [33:0] n1_r;
  logic [31:0] p2_r, p3_r;
  logic [18:0] t2_r;
  logic [38:0] m3_r;
  logic [31:0] q4_r;
  logic [16:0] hi;
  logic [16:0] lo;

  assign hi = n1_r[33:DIV_LO_W];
  assign lo = n1_r[DIV_LO_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= x[34];
      n1_r   <= 34'(x[34] ? (35'd0 - x) : x);
      neg2_r <= neg1_r;
      p2_r   <= 32'(hi * DIV_HI_MUL);
      t2_r   <= {1'b0, hi, 1'b0} + 19'(lo);
      neg3_r <= neg2_r;
      p3_r   <= p2_r;
      m3_r   <= 39'(t2_r * RECIP5);
      neg4_r <= neg3_r;
      q4_r   <= p3_r + 32'(m3_r >> RECIP_SH);
    end
  end

  assign q = neg4_r ? (32'd0 - q4_r) : q4_r;

endmodule

// ----- rtl/core/clock_offset_estimator.sv -----
// clock offset estimator top level: keep the shortest exchange of a round,
// emit round trip, master lead and a raw or per-cpu filtered offset
// depends on coe_pkg, coe_best, coe_raw, coe_div5
//
//   channel  direction  handshake            word
//   in_      input      in_valid / in_stall  coe_in_t  (one timestamp exchange)
//   out_     output     out_valid / out_stall coe_out_t (one result per round)
//   cfg_     input      cfg_we               raw_mode bit
//
// one exchange accepted per cycle while in_stall is low; out_valid rises once the last word
// of a round has passed the input, keep, raw, numerator, divider and output registers
// in filtered mode a last word is held off while an earlier last word is still
// in the pipe ahead of its filter write, since the per-cpu entry it reads is
// written only at the end
// reset is synchronous: round state, filter entries and raw_mode are cleared
// a stalled result freezes the whole pipe and raises in_stall while it is held
module clock_offset_estimator #(
  parameter int CPU_COUNT = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  coe_pkg::coe_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output coe_pkg::coe_out_t out_word,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import coe_pkg::*;

  // cpu_index is 3 bits, so at most eight entries are reachable
  localparam int          FILT_N  = (CPU_COUNT < 8) ? CPU_COUNT : 8;
  localparam int          FILT_W  = (FILT_N > 1) ? $clog2(FILT_N) : 1;
  localparam logic [6:0]  CPU_C7  = 7'(CPU_COUNT);

  // cpu_index modulo CPU_COUNT by repeated subtraction (narrow value), exact when CPU_COUNT is at least two
  function automatic logic [FILT_W-1:0] cpu_reduce(input logic [2:0] v);
    logic [6:0] t;
    t = {4'd0, v};
    for (int k = 0; k < 4; k++) begin
      if (t >= CPU_C7) begin
        t = t - CPU_C7;
      end
    end
    return t[FILT_W-1:0];
  endfunction

  logic              raw_mode_r;
  logic              adv;
  logic              acc;
  logic              hazard;
  logic              pend_b, pend_r;
  logic              kept_vld;
  coe_smp_t          kept;
  logic [FILT_W-1:0] kept_tag;
  logic              res_vld;
  coe_res_t          res;
  logic [FILT_W-1:0] res_tag;
  logic [31:0]       filt_r [FILT_N];
  logic [31:0]       old_f;
  logic              v5_r;
  coe_res_t          res5_r;
  logic [FILT_W-1:0] cpu5_r;
  logic [34:0]       x5_r;
  logic              sv_r   [DIV_LAT];
  coe_res_t          sres_r [DIV_LAT];
  logic [FILT_W-1:0] scpu_r [DIV_LAT];
  logic              side_pend;
  logic [31:0]       f_q;
  logic              out_valid_r;
  coe_out_t          out_word_r;

  // whole pipe moves unless a finished result is held
  assign adv = !out_valid_r || !out_stall;

  // last words in flight from the numerator register up to the filter write
  always_comb begin
    side_pend = v5_r;
    for (int i = 0; i < DIV_LAT; i++) begin
      side_pend = side_pend | sv_r[i];
    end
  end

  assign hazard   = in_word.last_sample && !raw_mode_r && (pend_b || pend_r || side_pend);
  assign in_stall = !adv || hazard;
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r <= 1'b0;
    end else if (cfg_we) begin
      raw_mode_r <= cfg_wdata;
    end
  end

  // input register and minimum span keep
  coe_best #(.TAG_W(FILT_W)) u_best (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .acc       (acc),
    .in_word   (in_word),
    .in_tag    (cpu_reduce(in_word.cpu_index)),
    .kept_vld  (kept_vld),
    .kept      (kept),
    .kept_tag  (kept_tag),
    .pend_last (pend_b)
  );

  // lead and raw midpoint offset
  coe_raw #(.TAG_W(FILT_W)) u_raw (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .kept_vld  (kept_vld),
    .kept      (kept),
    .kept_tag  (kept_tag),
    .res_vld   (res_vld),
    .res       (res),
    .res_tag   (res_tag),
    .pend_last (pend_r)
  );

  // filter numerator: 4*old + low 32 bits of raw, both sign extended
  assign old_f = filt_r[res_tag];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        sv_r[i] <= 1'b0;
      end
    end else if (adv) begin
      v5_r    <= res_vld;
      sv_r[0] <= v5_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        sv_r[i] <= sv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res5_r    <= res;
      cpu5_r    <= res_tag;
      x5_r      <= {old_f[31], old_f, 2'b00} + {{3{res.raw_offset[31]}}, res.raw_offset[31:0]};
      sres_r[0] <= res5_r;
      scpu_r[0] <= cpu5_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        sres_r[i] <= sres_r[i-1];
        scpu_r[i] <= scpu_r[i-1];
      end
    end
  end

  // (8*old + 2*new)/10 is the same as (4*old + new)/5
  coe_div5 u_div5 (
    .clk (clk),
    .en  (adv),
    .x   (x5_r),
    .q   (f_q)
  );

  // output register and filter write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < FILT_N; i++) begin
        filt_r[i] <= '0;
      end
    end else if (adv) begin
      out_valid_r <= sv_r[DIV_LAT-1];
      if (sv_r[DIV_LAT-1] && !raw_mode_r) begin
        filt_r[scpu_r[DIV_LAT-1]] <= f_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r.round_trip  <= sres_r[DIV_LAT-1].round_trip;
      out_word_r.master_lead <= sres_r[DIV_LAT-1].master_lead;
      out_word_r.offset_estimate <= raw_mode_r ? sres_r[DIV_LAT-1].raw_offset
                                               : {{32{f_q[31]}}, f_q};
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for clock_offset_estimator: directed table, then random rounds
// keeps its own shortest-exchange and per-cpu filter model to predict each result word
// depends on coe_pkg and the clock_offset_estimator rtl
`timescale 1ns / 100ps

module tb_top;
  import coe_pkg::*;

  localparam int CPU_N        = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int TAIL_CYCLES  = 24;
  localparam int STALL_LIMIT  = 1000;  // cycles without any handshake before giving up
  localparam int PHASE_WORDS  = 150;
  localparam int PHASE_COUNT  = 4;

  // one line of the directed table: either a mode write or an exchange word,
  // optionally with the result word typed in by hand
  typedef struct {
    bit       is_cfg;
    bit       cfg_val;
    coe_in_t  w;
    bit       pinned;
    coe_out_t pin;
  } plan_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  coe_in_t  in_word;
  logic     out_valid;
  logic     out_stall;
  coe_out_t out_word;
  logic     cfg_we;
  logic     cfg_wdata;

  // sideband that travels with the driven word: hand-typed result, if any
  logic     pin_on;
  coe_out_t pin_val;
  logic     quiet;   // high during the stretch with no idling on either side

  // predictor state
  logic [63:0] keep_send;
  logic [63:0] keep_recv;
  logic [63:0] keep_master;
  int          cpu_filter [CPU_N];
  logic        raw_sel;
  coe_out_t    pending_results [$];
  coe_out_t    want_res;

  plan_row_t   plan [$];
  int          errors   = 0;
  int          idle_run = 0;

  clock_offset_estimator #(
    .CPU_COUNT(CPU_N)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // kept sample goes back to "nothing kept": span all ones, beaten by no sample
  task automatic restart_round();
    keep_send   = '0;
    keep_recv   = '1;
    keep_master = '0;
  endtask

  // one accepted exchange: keep it if its span is strictly shorter, and on the
  // last word of a round queue the expected result and update the cpu filter
  task automatic track_exchange(input coe_in_t w, input bit pinned, input coe_out_t pin);
    logic [63:0] mid;
    logic [63:0] raw;
    longint      prev;
    longint      fresh;
    longint      flt;
    int          slot;
    coe_out_t    exp_res;
    if (w.receive_time - w.send_time < keep_recv - keep_send) begin
      keep_send   = w.send_time;
      keep_recv   = w.receive_time;
      keep_master = w.master_time;
    end
    if (!w.last_sample) return;
    exp_res.round_trip  = keep_recv - keep_send;
    exp_res.master_lead = keep_master - keep_send;
    // midpoint without overflow: halves, plus one when both are odd
    mid = (keep_send >> 1) + (keep_recv >> 1) + {63'd0, keep_send[0] & keep_recv[0]};
    raw = mid - keep_master;
    slot = int'(w.cpu_index) % CPU_N;
    if (raw_sel) begin
      exp_res.offset_estimate = raw;
    end else begin
      // (8*old + 2*new)/10 on signed values, truncated toward zero
      prev  = cpu_filter[slot];
      fresh = int'(raw[31:0]);
      flt   = (8 * prev + 2 * fresh) / 10;
      cpu_filter[slot] = int'(flt);
      exp_res.offset_estimate = longint'(cpu_filter[slot]);
    end
    if (pinned) exp_res = pin;
    pending_results.push_back(exp_res);
    restart_round();
  endtask

  // predictor, mode register and result check, all on sampled values
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_round();
      foreach (cpu_filter[i]) cpu_filter[i] = 0;
      raw_sel = 1'b0;
    end else begin
      if (cfg_we) raw_sel = cfg_wdata;
      if (in_valid && !in_stall) track_exchange(in_word, pin_on, pin_val);
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result word with nothing pending: %h", out_word));
        end else begin
          want_res = pending_results.pop_front();
          if (out_word.round_trip !== want_res.round_trip)
            flag_error($sformatf("round_trip %h, want %h",
                                 out_word.round_trip, want_res.round_trip));
          if (out_word.master_lead !== want_res.master_lead)
            flag_error($sformatf("master_lead %h, want %h",
                                 out_word.master_lead, want_res.master_lead));
          if (out_word.offset_estimate !== want_res.offset_estimate)
            flag_error($sformatf("offset_estimate %h, want %h",
                                 out_word.offset_estimate, want_res.offset_estimate));
        end
      end
    end
  end

  // receiver backpressure, off during the quiet stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 16);
    end
  end

  // watchdog: any handshake or mode write restarts the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_run <= 0;
      end else if (idle_run == STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  function automatic plan_row_t sample_row(input logic [63:0] s, m, r, input int cpu,
                                           input bit last);
    plan_row_t row;
    row.is_cfg            = 1'b0;
    row.cfg_val           = 1'b0;
    row.w.send_time       = s;
    row.w.master_time     = m;
    row.w.receive_time    = r;
    row.w.cpu_index       = cpu[2:0];
    row.w.last_sample     = last;
    row.pinned            = 1'b0;
    row.pin               = '0;
    return row;
  endfunction

  // last word of a round whose result is easy to read off by hand
  function automatic plan_row_t known_row(input logic [63:0] s, m, r, input int cpu,
                                          input logic [63:0] rt, lead, ofs);
    plan_row_t row;
    row                     = sample_row(s, m, r, cpu, 1'b1);
    row.pinned              = 1'b1;
    row.pin.round_trip      = rt;
    row.pin.master_lead     = lead;
    row.pin.offset_estimate = ofs;
    return row;
  endfunction

  function automatic plan_row_t mode_row(input bit raw);
    plan_row_t row;
    row        = sample_row('0, '0, '0, 0, 1'b0);
    row.is_cfg = 1'b1;
    row.cfg_val = raw;
    return row;
  endfunction

  // counter values biased toward the ends and the sign boundary
  function automatic logic [63:0] pick_stamp();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, 63'd0} - 64'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // present one word, idling at random first, and hold it until accepted
  task automatic send_exchange(input coe_in_t w, input bit pinned, input coe_out_t pin);
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    pin_on   <= pinned;
    pin_val  <= pin;
    do @(posedge clk); while (in_stall);
  endtask

  // mode change only with the block idle: every result back, pipe drained
  task automatic write_mode(input bit raw);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= raw;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one random round: mostly well-formed exchanges ending in a last word,
  // with some noise words that may end the round early
  task automatic play_round(output int n);
    logic [63:0] base;
    logic [63:0] s;
    logic [63:0] span;
    logic [63:0] prev_span;
    logic [63:0] x;
    logic [31:0] bits;
    coe_in_t     w;
    coe_out_t    none;
    int          cpu;
    n         = $urandom_range(1, 6);
    cpu       = $urandom_range(0, 7);
    base      = pick_stamp();
    prev_span = '0;
    none      = '0;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 85) begin
        case ($urandom_range(9))
          0:       span = prev_span;   // equal span, earlier one must stay
          1:       span = '1;          // never beats the initial span
          2:       span = {$urandom, $urandom};
          default: span = 64'($urandom_range(0, 4000));
        endcase
        x = {$urandom, $urandom};
        s = base + 64'($urandom_range(0, 100000));
        w.send_time    = s;
        w.receive_time = s + span;
        // master near the midpoint, off by a signed 32-bit amount, or anywhere
        w.master_time  = ($urandom_range(3) == 0) ? x :
                         s + (span >> 1) - {{32{x[31]}}, x[31:0]};
        w.cpu_index    = cpu[2:0];
        w.last_sample  = (k == n - 1);
        prev_span      = span;
      end else begin
        bits = $urandom;
        w.send_time    = pick_stamp();
        w.master_time  = pick_stamp();
        w.receive_time = pick_stamp();
        w.cpu_index    = bits[2:0];
        w.last_sample  = bits[3];
      end
      send_exchange(w, 1'b0, none);
    end
  endtask

  initial begin
    int sent;
    int n;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    pin_on    = 1'b0;
    pin_val   = '0;
    quiet     = 1'b0;

    // filtered mode, straight after reset
    // no sample beats the all-ones span: result from the cleared round state
    plan.push_back(known_row(64'd0, 64'd5, '1, 0, '1, 64'd0, 64'd0));
    plan.push_back(known_row(64'd100, 64'd150, 64'd200, 1, 64'd100, 64'd50, 64'd0));
    plan.push_back(known_row(64'd0, 64'd0, 64'd0, 2, 64'd0, 64'd0, 64'd0));
    // both stamps odd and at the top: midpoint carries the extra one
    plan.push_back(known_row('1, 64'd0, '1, 3, 64'd0, 64'd1, 64'd0));
    // filter extremes: largest and smallest 32-bit offset
    plan.push_back(known_row(64'd0, 64'hFFFF_FFFF_8000_0001, 64'd0, 4,
                             64'd0, 64'hFFFF_FFFF_8000_0001, 64'd429496729));
    plan.push_back(known_row(64'd0, 64'h0000_0000_8000_0000, 64'd0, 5,
                             64'd0, 64'h0000_0000_8000_0000, -64'sd429496729));
    // multi-word round with a shorter span in the middle and a tie after it
    plan.push_back(sample_row(64'd1000, 64'd1100, 64'd1300, 6, 1'b0));
    plan.push_back(sample_row(64'd2000, 64'd2050, 64'd2100, 6, 1'b0));
    plan.push_back(sample_row(64'd3000, 64'd2000, 64'd3100, 6, 1'b0));
    plan.push_back(sample_row(64'd4000, 64'd4000, 64'd4200, 6, 1'b1));
    // span that wraps past zero, then a last word that is not kept
    plan.push_back(sample_row(64'hFFFF_FFFF_FFFF_FFF0, 64'd5, 64'h10, 7, 1'b0));
    plan.push_back(sample_row(64'd5, 64'd9, 64'd3, 7, 1'b1));
    // filter entries that already hold a value
    plan.push_back(sample_row(64'd3, 64'd1, 64'd7, 4, 1'b1));
    plan.push_back(sample_row(64'hFFFF_FFFF_0000_0001, 64'h0000_0001_0000_0000,
                              64'hFFFF_FFFF_0000_000A, 5, 1'b1));
    plan.push_back(sample_row(64'd1, 64'hDEAD_BEEF_0123_4567, 64'd1, 5, 1'b1));
    // raw mode
    plan.push_back(mode_row(1'b1));
    plan.push_back(known_row('1, 64'd0, '1, 0, 64'd0, 64'd1, '1));
    plan.push_back(known_row(64'd0, 64'h8000_0000_0000_0000, 64'd2, 1,
                             64'd2, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001));
    plan.push_back(known_row(64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 7,
                             64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001));
    plan.push_back(sample_row(64'd10, 64'd20, 64'd40, 3, 1'b0));
    plan.push_back(sample_row(64'd11, 64'd12, 64'd30, 3, 1'b1));
    // back to filtered mode
    plan.push_back(mode_row(1'b0));
    plan.push_back(sample_row(64'd77, 64'hFFFF_FFFF_FFFF_0000, 64'd91, 4, 1'b1));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_mode(plan[i].cfg_val);
      else send_exchange(plan[i].w, plan[i].pinned, plan[i].pin);
    end

    // random phases alternate the mode; the third runs with no idling at all
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      write_mode(phase % 2 == 0);
      quiet <= (phase == 2);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        play_round(n);
        sent += n;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
